### rtl/hashed_perceptron_classifier_top_defines.svh
// ----------------------------------------------------------------------------
// hashed perceptron classifier assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef HASHED_PERCEPTRON_CLASSIFIER_TOP_DEFINES_SVH
`define HASHED_PERCEPTRON_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define HPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hpc_pkg.sv
// ----------------------------------------------------------------------------
// hpc_pkg
// shared constants, types and saturation helpers of the perceptron classifier
// ----------------------------------------------------------------------------
package hpc_pkg;

    localparam int MAX_FEATURE_BITS_DEF = 16;
    localparam int MAX_FEATURES_DEF     = 64;

    localparam int INDEX_W  = 32;
    localparam int VALUE_W  = 16;
    localparam int WEIGHT_W = 32;
    localparam int ACC_W    = 48;
    localparam int FB_W     = 5;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    localparam logic [FB_W-1:0] FEATURE_BITS_RESET = FB_W'(16);

    // register index as carried in paddr[CFG_AW-1:2]
    localparam logic REG_FEATURE_BITS = 1'b0;

    typedef struct packed {
        logic [FB_W-1:0] feature_bits;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_DONE,
        ST_TR_START,
        ST_TR_RDW,
        ST_TR_WR,
        ST_OUT
    } state_t;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[ACC_W] == v[ACC_W-1])
        begin
            r = v[ACC_W-1:0];
        end
        else if (v[ACC_W])
        begin
            r = {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [WEIGHT_W-1:0] sat_weight(
        input logic signed [WEIGHT_W+1:0] v
    );
        logic signed [WEIGHT_W-1:0] r;
        if ((v[WEIGHT_W+1:WEIGHT_W-1] == 3'b000) || (v[WEIGHT_W+1:WEIGHT_W-1] == 3'b111))
        begin
            r = v[WEIGHT_W-1:0];
        end
        else if (v[WEIGHT_W+1])
        begin
            r = {1'b1, {(WEIGHT_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(WEIGHT_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### rtl/hashed_perceptron_classifier_top.sv
// ----------------------------------------------------------------------------
// hashed_perceptron_classifier_top
// online perceptron over a hashed weight table, top level
// ----------------------------------------------------------------------------
// usage
//   input stream (s_*): one word per sparse feature, index and q8.8 value in
//   s_tdata, op and label in s_tuser, s_tlast closes the sample
//   result stream (m_*): one word per sample, q32.16 prediction in m_tdata,
//   updated and features_dropped flags in m_tuser
//   apb port: feature_bits at byte address 0, pready always high
// feature path
//   per buffered feature: weight ram read, then multiply with the input held off;
//   the accumulate overlaps the next feature; a dropped feature skips all three
// result path
//   last feature to m_tvalid: READ (not for a dropped one), WAIT, DONE, OUT;
//   training adds TR_START, then TR_RDW and TR_WR per buffered feature, before OUT
// reset
//   weights are swept to zero, one entry per cycle, over all 2**MAX_FEATURE_BITS
//   entries; s_tready stays low meanwhile, apb writes are taken as ever
// stall
//   a held result stays in the output register; features of the next sample
//   are still taken, its result waits until the register frees up
// ----------------------------------------------------------------------------
module hashed_perceptron_classifier_top
    import hpc_pkg::*;
#(
    parameter int MAX_FEATURE_BITS = MAX_FEATURE_BITS_DEF,
    parameter int MAX_FEATURES     = MAX_FEATURES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // apb configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [CFG_AW-1:0]          paddr,
    input  logic [CFG_DW-1:0]          pwdata,
    output logic [CFG_DW-1:0]          prdata,
    output logic                       pready,
    // feature stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [INDEX_W+VALUE_W-1:0] s_tdata,   // feature_index, feature_value
    input  logic [1:0]                 s_tuser,   // op, label_positive
    input  logic                       s_tlast,   // last_feature
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ACC_W-1:0]           m_tdata,   // prediction
    output logic [1:0]                 m_tuser    // updated, features_dropped
);

    localparam int BUF_AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int BUF_W  = MAX_FEATURE_BITS + VALUE_W;

    cfg_t cfg;

    // weight ram port
    logic                        w_we;
    logic [MAX_FEATURE_BITS-1:0] w_waddr, w_raddr;
    logic [WEIGHT_W-1:0]         w_wdata, w_rdata;

    // sample buffer port: masked index low, value high
    logic                        b_we;
    logic [BUF_AW-1:0]           b_waddr, b_raddr;
    logic [BUF_W-1:0]            b_wdata, b_rdata;

    hpc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // one q24.8 weight per table entry
    hpc_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (2 ** MAX_FEATURE_BITS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    // features of the current sample, replayed by the training pass
    hpc_ram #(
        .WIDTH (BUF_W),
        .DEPTH (MAX_FEATURES)
    ) u_sample_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    hpc_core #(
        .MAX_FEATURE_BITS (MAX_FEATURE_BITS),
        .MAX_FEATURES     (MAX_FEATURES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .w_we     (w_we),
        .w_waddr  (w_waddr),
        .w_wdata  (w_wdata),
        .w_raddr  (w_raddr),
        .w_rdata  (w_rdata),
        .b_we     (b_we),
        .b_waddr  (b_waddr),
        .b_wdata  (b_wdata),
        .b_raddr  (b_raddr),
        .b_rdata  (b_rdata)
    );

endmodule

### rtl/hpc_ram.sv
// ----------------------------------------------------------------------------
// hpc_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hpc_ram
    import hpc_pkg::*;
#(
    parameter int WIDTH = WEIGHT_W,
    parameter int DEPTH = 2 ** MAX_FEATURE_BITS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/hpc_cfg.sv
// ----------------------------------------------------------------------------
// hpc_cfg
// apb register file holding the feature_bits register
// ----------------------------------------------------------------------------
module hpc_cfg
    import hpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [FB_W-1:0] fb_reg;
    logic            hit;

    assign hit    = (paddr[CFG_AW-1:2] == REG_FEATURE_BITS);
    assign pready = 1'b1;
    assign prdata = hit ? CFG_DW'(fb_reg) : '0;
    assign cfg.feature_bits = fb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_reg <= FEATURE_BITS_RESET;
        end
        else if (psel && penable && pwrite && pready && hit)
        begin
            fb_reg <= pwdata[FB_W-1:0];
        end
    end

endmodule

### rtl/hpc_core.sv
// ----------------------------------------------------------------------------
// hpc_core
// sequencer and datapath: dot product on arrival, training pass, result word
// ----------------------------------------------------------------------------
module hpc_core
    import hpc_pkg::*;
#(
    parameter int MAX_FEATURE_BITS = MAX_FEATURE_BITS_DEF,
    parameter int MAX_FEATURES     = MAX_FEATURES_DEF,
    localparam int BUF_AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
    localparam int BUF_W  = MAX_FEATURE_BITS + VALUE_W,
    localparam int CW     = $clog2(MAX_FEATURES + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfg_t                        cfg,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [INDEX_W+VALUE_W-1:0]  s_tdata,
    input  logic [1:0]                  s_tuser,
    input  logic                        s_tlast,
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ACC_W-1:0]            m_tdata,
    output logic [1:0]                  m_tuser,
    // weight ram
    output logic                        w_we,
    output logic [MAX_FEATURE_BITS-1:0] w_waddr,
    output logic [WEIGHT_W-1:0]         w_wdata,
    output logic [MAX_FEATURE_BITS-1:0] w_raddr,
    input  logic [WEIGHT_W-1:0]         w_rdata,
    // sample buffer ram
    output logic                        b_we,
    output logic [BUF_AW-1:0]           b_waddr,
    output logic [BUF_W-1:0]            b_wdata,
    output logic [BUF_AW-1:0]           b_raddr,
    input  logic [BUF_W-1:0]            b_rdata
);

    localparam logic [FB_W-1:0] FB_LIMIT = FB_W'(MAX_FEATURE_BITS);

    state_t state_reg, state_next;

    logic [CW-1:0]               count_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic                        ovf_reg;
    logic                        op_reg, pos_reg, last_reg;
    logic signed [VALUE_W-1:0]   val_reg;
    logic signed [ACC_W-1:0]     prod_reg;
    logic                        prod_vld_reg;
    logic [CW-1:0]               tr_idx_reg;
    logic [MAX_FEATURE_BITS-1:0] upd_idx_reg;
    logic signed [VALUE_W:0]     delta_reg;
    logic                        upd_reg;
    logic [MAX_FEATURE_BITS-1:0] clr_reg;
    logic                        m_tvalid_reg;
    logic [ACC_W-1:0]            m_tdata_reg;
    logic [1:0]                  m_tuser_reg;

    logic                        accept, full, mistake, out_load;
    logic [FB_W-1:0]             fb_eff;
    logic [MAX_FEATURE_BITS-1:0] idx_mask, idx_masked;
    logic [CW-1:0]               tr_next;
    logic signed [ACC_W-1:0]     prod_full;
    logic signed [ACC_W:0]       acc_sum;
    logic signed [VALUE_W:0]     buf_val;
    logic signed [WEIGHT_W+1:0]  w_sum;

    // index mask from the register, clipped to the table size
    assign fb_eff = (cfg.feature_bits > FB_LIMIT) ? FB_LIMIT : cfg.feature_bits;

    always_comb
    begin
        for (int b = 0; b < MAX_FEATURE_BITS; b++)
        begin
            idx_mask[b] = (FB_W'(b) < fb_eff);
        end
    end

    assign idx_masked = s_tdata[MAX_FEATURE_BITS-1:0] & idx_mask;
    assign accept     = s_tvalid && s_tready;
    assign full       = (count_reg == CW'(MAX_FEATURES));
    assign tr_next    = count_reg == count_reg ? tr_idx_reg + 1'b1 : tr_idx_reg;
    assign mistake    = pos_reg ? (acc_reg <= 0) : (acc_reg >= 0);
    assign prod_full  = $signed(w_rdata) * val_reg;
    assign acc_sum    = {acc_reg[ACC_W-1], acc_reg} + {prod_reg[ACC_W-1], prod_reg};
    assign buf_val    = {b_rdata[BUF_W-1], b_rdata[BUF_W-1:MAX_FEATURE_BITS]};
    assign w_sum      = {{2{w_rdata[WEIGHT_W-1]}}, w_rdata}
                      + {{(WEIGHT_W-VALUE_W+1){delta_reg[VALUE_W]}}, delta_reg};

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && !full)
                begin
                    state_next = ST_READ;
                end
                else if (accept && s_tlast)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_READ:     state_next = last_reg ? ST_WAIT : ST_IDLE;
            ST_WAIT:     state_next = ST_DONE;
            ST_DONE:     state_next = (op_reg && mistake) ? ST_TR_START : ST_OUT;
            ST_TR_START: state_next = ST_TR_RDW;
            ST_TR_RDW:   state_next = ST_TR_WR;
            ST_TR_WR:    state_next = (tr_next == count_reg) ? ST_OUT : ST_TR_RDW;
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        w_we     = 1'b0;
        w_waddr  = upd_idx_reg;
        w_wdata  = sat_weight(w_sum);
        w_raddr  = idx_masked;
        b_we     = 1'b0;
        b_waddr  = count_reg[BUF_AW-1:0];
        b_wdata  = {s_tdata[INDEX_W+VALUE_W-1:INDEX_W], idx_masked};
        b_raddr  = tr_next[BUF_AW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                w_we    = 1'b1;
                w_waddr = clr_reg;
                w_wdata = '0;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                b_we     = accept && !full;
            end
            ST_TR_START:
            begin
                b_raddr = '0;
            end
            ST_TR_RDW:
            begin
                w_raddr = b_rdata[MAX_FEATURE_BITS-1:0];
            end
            ST_TR_WR:
            begin
                w_we = 1'b1;
            end
            ST_OUT:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            count_reg    <= '0;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            op_reg       <= 1'b0;
            pos_reg      <= 1'b0;
            last_reg     <= 1'b0;
            prod_vld_reg <= 1'b0;
            tr_idx_reg   <= '0;
            upd_reg      <= 1'b0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prod_vld_reg <= (state_reg == ST_READ);

            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end

            if (accept)
            begin
                op_reg   <= s_tuser[0];
                pos_reg  <= s_tuser[1];
                last_reg <= s_tlast;
            end

            if (out_load)
            begin
                count_reg <= '0;
                acc_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                if (accept && !full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (accept && full)
                begin
                    ovf_reg <= 1'b1;
                end
                if (prod_vld_reg)
                begin
                    acc_reg <= sat_acc(acc_sum);
                end
            end

            if (state_reg == ST_TR_START)
            begin
                tr_idx_reg <= '0;
            end
            else if (state_reg == ST_TR_WR)
            begin
                tr_idx_reg <= tr_next;
            end

            if (state_reg == ST_DONE)
            begin
                upd_reg <= op_reg && mistake;
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg <= s_tdata[INDEX_W+VALUE_W-1:INDEX_W];
        end
        if (state_reg == ST_READ)
        begin
            prod_reg <= prod_full;
        end
        if (state_reg == ST_TR_RDW)
        begin
            upd_idx_reg <= b_rdata[MAX_FEATURE_BITS-1:0];
            delta_reg   <= pos_reg ? buf_val : -buf_val;
        end
        if (out_load)
        begin
            m_tdata_reg <= acc_reg;
            m_tuser_reg <= {ovf_reg, upd_reg};
        end
    end

endmodule

### rtl/hpc_checker.sv
// ----------------------------------------------------------------------------
// hpc_checker
// port-level checks of the perceptron classifier, bound to the top level
// ----------------------------------------------------------------------------
`include "hashed_perceptron_classifier_top_defines.svh"

module hpc_checker
    import hpc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             s_tlast,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [ACC_W-1:0] m_tdata,
    input logic [1:0]       m_tuser
);

    // a held result word keeps its payload
    `HPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // taking the last feature of a sample always holds the input off for the core
    `HPC_ASSERT_NEXT(a_last_gap, s_tvalid && s_tready && s_tlast, !s_tready, "input taken straight after a last feature")

    // a result is loaded only while the input side is held off
    `HPC_ASSERT_NOW(a_out_load, $rose(m_tvalid), !$past(s_tready), "result appeared while features were being taken")

endmodule

bind hashed_perceptron_classifier_top hpc_checker u_hpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
